// ===== sv/clc_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// clc_pkg
// Shared types and constants for the set-associative LRU cache model.
// ----------------------------------------------------------------------------
package clc_pkg;

	localparam int ADDR_W     = 32;
	localparam int TAG_W      = 32;
	localparam int CNT_W      = 32;
	localparam int PEN_W      = 48;
	localparam int COST_W     = 16;
	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 16;
	localparam int IDX_MAX_W  = 7;   // index_bits reaches 7, so the masked index is 7 bits
	localparam int Q_DEPTH    = 2;

	// configuration register indexes
	localparam logic [CFG_IDX_W-1:0] REG_OFFSET_BITS  = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_INDEX_BITS   = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_HIT_COST     = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_MISS_COST    = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_CHAIN_ENABLE = 3'd4;

	typedef struct packed {
		logic [4:0]        offset_bits;
		logic [2:0]        index_bits;
		logic [COST_W-1:0] hit_cost;
		logic [COST_W-1:0] miss_cost;
		logic              chain_enable;
	} cfg_t;

	localparam cfg_t CFG_RESET = '{
		offset_bits:  5'd5,
		index_bits:   3'd1,
		hit_cost:     16'd4,
		miss_cost:    16'd0,
		chain_enable: 1'b0
	};

	typedef enum logic [1:0] {
		BK_CLEAR,
		BK_IDLE,
		BK_LOOK
	} bk_state_t;

endpackage

// ===== sv/clc_ram.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// clc_ram
// Simple dual-port RAM: one write port, one read port with registered data.
// ----------------------------------------------------------------------------
module clc_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 64
) (
	input  logic                                       clk,
	input  logic                                       we,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  logic [WIDTH-1:0]                           wdata,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic [WIDTH-1:0]                           rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

// ===== sv/clc_queue.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// clc_queue
// Short FIFO of decoded requests between the front end and the back end.
// ----------------------------------------------------------------------------
module clc_queue #(
	parameter int WIDTH = 38
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push,
	input  logic [WIDTH-1:0] push_data,
	input  logic             pop,
	output logic [WIDTH-1:0] head,
	output logic             empty,
	output logic             full
);

	localparam int PW = (clc_pkg::Q_DEPTH > 1) ? $clog2(clc_pkg::Q_DEPTH) : 1;

	logic [WIDTH-1:0] entries_q [clc_pkg::Q_DEPTH];
	logic [PW-1:0]    wr_ptr_q;
	logic [PW-1:0]    rd_ptr_q;
	logic [PW:0]      cnt_q;

	assign empty = (cnt_q == '0);
	assign full  = (cnt_q == (PW+1)'(clc_pkg::Q_DEPTH));
	assign head  = entries_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			entries_q[wr_ptr_q] <= push_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == PW'(clc_pkg::Q_DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == PW'(clc_pkg::Q_DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			case ({push, pop})
				2'b10:   cnt_q <= cnt_q + 1'b1;
				2'b01:   cnt_q <= cnt_q - 1'b1;
				default: cnt_q <= cnt_q;
			endcase
		end
	end

endmodule

// ===== sv/clc_front.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// clc_front
// Accepts an access and splits its address into set index and tag.
// ----------------------------------------------------------------------------
module clc_front #(
	parameter int NUM_SETS = 64,
	parameter int SET_W    = 6
) (
	input  logic                           start,
	input  logic [clc_pkg::ADDR_W-1:0]     address,
	input  clc_pkg::cfg_t                  cfg,
	input  logic                           q_full,
	input  logic                           clearing,
	output logic                           busy,
	output logic                           push,
	output logic [clc_pkg::TAG_W-1:0]      push_tag,
	output logic [SET_W-1:0]               push_set
);

	localparam int NIDX = 1 << clc_pkg::IDX_MAX_W;

	logic [SET_W-1:0]              mod_tbl [NIDX];
	logic [clc_pkg::ADDR_W-1:0]    shifted;
	logic [clc_pkg::IDX_MAX_W-1:0] idx_mask;
	logic [clc_pkg::IDX_MAX_W-1:0] idx_raw;
	logic [5:0]                    tag_sh;

	// index reduced modulo the set count, worked out at elaboration
	for (genvar g = 0; g < NIDX; g++) begin : g_mod
		assign mod_tbl[g] = SET_W'(g % NUM_SETS);
	end

	assign busy     = q_full | clearing;
	assign push     = start & ~busy;

	assign shifted  = address >> cfg.offset_bits;
	assign idx_mask = clc_pkg::IDX_MAX_W'((8'd1 << cfg.index_bits) - 8'd1);
	assign idx_raw  = shifted[clc_pkg::IDX_MAX_W-1:0] & idx_mask;
	assign push_set = mod_tbl[idx_raw];

	// shift of 32 or more leaves a zero tag
	assign tag_sh   = {1'b0, cfg.offset_bits} + {3'b000, cfg.index_bits};
	assign push_tag = tag_sh[5] ? '0 : (address >> tag_sh[4:0]);

endmodule

// ===== sv/clc_back.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// clc_back
// Tag lookup, LRU update and hit/miss accounting; one set read, one write-back.
// ----------------------------------------------------------------------------
module clc_back #(
	parameter int NUM_SETS = 64,
	parameter int NUM_WAYS = 8,
	parameter int SET_W    = 6
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  clc_pkg::cfg_t              cfg,
	input  logic                       q_valid,
	input  logic [clc_pkg::TAG_W-1:0]  q_tag,
	input  logic [SET_W-1:0]           q_set,
	output logic                       q_pop,
	output logic                       clearing,
	output logic                       done,
	output logic                       hit,
	output logic                       forward_miss,
	output logic [clc_pkg::CNT_W-1:0]  hit_total,
	output logic [clc_pkg::CNT_W-1:0]  miss_total,
	output logic [clc_pkg::PEN_W-1:0]  penalty_sum
);

	localparam int RW    = (NUM_WAYS > 1) ? $clog2(NUM_WAYS) : 1;
	localparam int WW    = (NUM_WAYS > 1) ? $clog2(NUM_WAYS) : 1;
	localparam int TW    = clc_pkg::TAG_W;
	localparam int EW    = TW + 1 + RW;     // tag, valid, rank per way
	localparam int ROW_W = NUM_WAYS * EW;

	clc_pkg::bk_state_t state_q, state_d;

	logic [SET_W-1:0]          clr_cnt_q;
	logic [TW-1:0]             tag_s1;
	logic [SET_W-1:0]          set_s1;
	logic                      done_q, hit_q, fwd_q;
	logic [clc_pkg::CNT_W-1:0] hit_cnt_q, miss_cnt_q;
	logic [clc_pkg::PEN_W-1:0] pen_q;

	logic                      ram_we;
	logic [SET_W-1:0]          ram_waddr;
	logic [ROW_W-1:0]          ram_wdata;
	logic [ROW_W-1:0]          ram_rdata;
	logic                      lookup;

	logic [TW-1:0]             way_tag  [NUM_WAYS];
	logic [RW-1:0]             way_rank [NUM_WAYS];
	logic [NUM_WAYS-1:0]       way_vld;
	logic [NUM_WAYS-1:0]       match;
	logic                      any_hit;
	logic                      has_free;
	logic [WW-1:0]             hit_way, free_way, victim_way, fill_way;
	logic [RW-1:0]             hit_rank;
	logic [ROW_W-1:0]          new_row;
	logic [clc_pkg::COST_W-1:0] cost;
	logic [clc_pkg::PEN_W:0]   pen_add;

	clc_ram #(
		.WIDTH (ROW_W),
		.DEPTH (NUM_SETS)
	) u_ram (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.raddr (q_set),
		.rdata (ram_rdata)
	);

	// ---- set evaluation on the row read back from the RAM
	always_comb begin
		for (int w = 0; w < NUM_WAYS; w++) begin
			way_tag[w]  = ram_rdata[w*EW +: TW];
			way_vld[w]  = ram_rdata[w*EW + TW];
			way_rank[w] = ram_rdata[w*EW + TW + 1 +: RW];
			match[w]    = way_vld[w] && (way_tag[w] == tag_s1);
		end
		any_hit  = |match;
		has_free = ~&way_vld;

		// lowest-numbered match and lowest-numbered free way
		hit_way  = '0;
		free_way = '0;
		for (int w = NUM_WAYS - 1; w >= 0; w--) begin
			if (match[w]) begin
				hit_way = WW'(w);
			end
			if (!way_vld[w]) begin
				free_way = WW'(w);
			end
		end
		// in a full set the ranks are a permutation, so the oldest has the top rank
		victim_way = '0;
		for (int w = 0; w < NUM_WAYS; w++) begin
			if (way_rank[w] == RW'(NUM_WAYS - 1)) begin
				victim_way = WW'(w);
			end
		end
		fill_way = has_free ? free_way : victim_way;
		hit_rank = way_rank[hit_way];

		for (int w = 0; w < NUM_WAYS; w++) begin
			new_row[w*EW +: EW] = ram_rdata[w*EW +: EW];
			if (any_hit) begin
				if (WW'(w) == hit_way) begin
					new_row[w*EW + TW + 1 +: RW] = '0;
				end else if (way_vld[w] && (way_rank[w] < hit_rank)) begin
					new_row[w*EW + TW + 1 +: RW] = way_rank[w] + 1'b1;
				end
			end else begin
				if (WW'(w) == fill_way) begin
					new_row[w*EW +: EW] = {{RW{1'b0}}, 1'b1, tag_s1};
				end else if (way_vld[w]) begin
					new_row[w*EW + TW + 1 +: RW] = way_rank[w] + 1'b1;
				end
			end
		end

		if (any_hit) begin
			cost = cfg.hit_cost;
		end else if (cfg.chain_enable) begin
			cost = '0;
		end else begin
			cost = cfg.miss_cost;
		end
		pen_add = {1'b0, pen_q} + (clc_pkg::PEN_W+1)'(cost);
	end

	// ---- sequencer: clearing pass, read, write-back
	always_comb begin
		state_d   = state_q;
		q_pop     = 1'b0;
		ram_we    = 1'b0;
		ram_waddr = set_s1;
		ram_wdata = new_row;
		clearing  = 1'b0;
		lookup    = 1'b0;
		case (state_q)
			clc_pkg::BK_CLEAR: begin
				clearing  = 1'b1;
				ram_we    = 1'b1;
				ram_waddr = clr_cnt_q;
				ram_wdata = '0;
				if (clr_cnt_q == SET_W'(NUM_SETS - 1)) begin
					state_d = clc_pkg::BK_IDLE;
				end
			end
			clc_pkg::BK_IDLE: begin
				if (q_valid) begin
					q_pop   = 1'b1;
					state_d = clc_pkg::BK_LOOK;
				end
			end
			clc_pkg::BK_LOOK: begin
				ram_we  = 1'b1;
				lookup  = 1'b1;
				state_d = clc_pkg::BK_IDLE;
			end
			default: begin
				state_d = clc_pkg::BK_CLEAR;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= clc_pkg::BK_CLEAR;
			clr_cnt_q <= '0;
		end else begin
			state_q <= state_d;
			if (clearing) begin
				clr_cnt_q <= clr_cnt_q + 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (q_pop) begin
			tag_s1 <= q_tag;
			set_s1 <= q_set;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done_q     <= 1'b0;
			hit_q      <= 1'b0;
			fwd_q      <= 1'b0;
			hit_cnt_q  <= '0;
			miss_cnt_q <= '0;
			pen_q      <= '0;
		end else begin
			done_q <= lookup;
			if (lookup) begin
				hit_q <= any_hit;
				fwd_q <= ~any_hit & cfg.chain_enable;
				if (any_hit && (hit_cnt_q != '1)) begin
					hit_cnt_q <= hit_cnt_q + 1'b1;
				end
				if (!any_hit && (miss_cnt_q != '1)) begin
					miss_cnt_q <= miss_cnt_q + 1'b1;
				end
				pen_q <= pen_add[clc_pkg::PEN_W] ? '1 : pen_add[clc_pkg::PEN_W-1:0];
			end
		end
	end

	assign done         = done_q;
	assign hit          = hit_q;
	assign forward_miss = fwd_q;
	assign hit_total    = hit_cnt_q;
	assign miss_total   = miss_cnt_q;
	assign penalty_sum  = pen_q;

endmodule

// ===== sv/set_assoc_lru_cache_model_core.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// set_assoc_lru_cache_model_core
// Set-associative tag store with true LRU replacement and hit/miss accounting.
// ----------------------------------------------------------------------------
// After reset the block sweeps its set RAM once, one set per cycle, and holds
// busy high meanwhile. An access is taken when start is high and busy is
// low; the front end decodes set and tag and places the access in a
// two-entry queue, so start may be raised again at once. The back end takes
// each access through an idle state that reads the whole set from the RAM,
// then a lookup state that compares tags, updates the ranks, writes the set
// back and counts; it takes no new access until it has finished the last,
// and busy rises when the queue is full. Each result appears for a single
// cycle with done high; the receiver must take it then, as the block cannot
// be held off. Configuration writes must only be issued while no access is
// outstanding.
module set_assoc_lru_cache_model_core #(
	parameter int NUM_SETS = 64,
	parameter int NUM_WAYS = 8
) (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               cfg_we,
	input  logic [clc_pkg::CFG_IDX_W-1:0]      cfg_index,
	input  logic [clc_pkg::CFG_DATA_W-1:0]     cfg_data,
	input  logic                               start,
	output logic                               busy,
	input  logic [clc_pkg::ADDR_W-1:0]         address,
	output logic                               done,
	output logic                               hit,
	output logic                               forward_miss,
	output logic [clc_pkg::CNT_W-1:0]          hit_total,
	output logic [clc_pkg::CNT_W-1:0]          miss_total,
	output logic [clc_pkg::PEN_W-1:0]          penalty_sum
);

	localparam int SET_W = (NUM_SETS > 1) ? $clog2(NUM_SETS) : 1;
	localparam int QW    = clc_pkg::TAG_W + SET_W;

	clc_pkg::cfg_t              cfg_q;
	logic                       push;
	logic [clc_pkg::TAG_W-1:0]  push_tag;
	logic [SET_W-1:0]           push_set;
	logic [QW-1:0]              q_head;
	logic                       q_empty, q_full, q_pop;
	logic                       clearing;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q <= clc_pkg::CFG_RESET;
		end else if (cfg_we) begin
			case (cfg_index)
				clc_pkg::REG_OFFSET_BITS:  cfg_q.offset_bits  <= cfg_data[4:0];
				clc_pkg::REG_INDEX_BITS:   cfg_q.index_bits   <= cfg_data[2:0];
				clc_pkg::REG_HIT_COST:     cfg_q.hit_cost     <= cfg_data;
				clc_pkg::REG_MISS_COST:    cfg_q.miss_cost    <= cfg_data;
				clc_pkg::REG_CHAIN_ENABLE: cfg_q.chain_enable <= cfg_data[0];
				default: ;
			endcase
		end
	end

	clc_front #(
		.NUM_SETS (NUM_SETS),
		.SET_W    (SET_W)
	) u_front (
		.start    (start),
		.address  (address),
		.cfg      (cfg_q),
		.q_full   (q_full),
		.clearing (clearing),
		.busy     (busy),
		.push     (push),
		.push_tag (push_tag),
		.push_set (push_set)
	);

	clc_queue #(
		.WIDTH (QW)
	) u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_data ({push_tag, push_set}),
		.pop       (q_pop),
		.head      (q_head),
		.empty     (q_empty),
		.full      (q_full)
	);

	clc_back #(
		.NUM_SETS (NUM_SETS),
		.NUM_WAYS (NUM_WAYS),
		.SET_W    (SET_W)
	) u_back (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg          (cfg_q),
		.q_valid      (~q_empty),
		.q_tag        (q_head[SET_W +: clc_pkg::TAG_W]),
		.q_set        (q_head[SET_W-1:0]),
		.q_pop        (q_pop),
		.clearing     (clearing),
		.done         (done),
		.hit          (hit),
		.forward_miss (forward_miss),
		.hit_total    (hit_total),
		.miss_total   (miss_total),
		.penalty_sum  (penalty_sum)
	);

	// back end passes through its idle state between transactions, so done is never high twice in a row
	a_done_spacing: assert property (@(posedge clk) disable iff (!arst_n)
		done |=> !done)
		else $error("done on consecutive cycles");

	a_fwd_chain: assert property (@(posedge clk) disable iff (!arst_n)
		(done && forward_miss) |-> (cfg_q.chain_enable && !hit))
		else $error("forward_miss without chaining or on a hit");

	a_hit_count: assert property (@(posedge clk) disable iff (!arst_n)
		(done && hit && ($past(hit_total) != '1)) |-> (hit_total == $past(hit_total) + 1'b1))
		else $error("hit count did not advance");

	a_miss_count: assert property (@(posedge clk) disable iff (!arst_n)
		(done && !hit) |-> ($stable(hit_total) && (miss_total != '0)))
		else $error("miss changed hit count or left miss count at zero");

endmodule
